// File: rtl/edn_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and reset constants of the exposure day/night decider.
package edn_pkg;

  localparam int unsigned ExpW     = 21;
  localparam int unsigned ToneW    = 8;
  localparam int unsigned TempW    = 16;
  localparam int unsigned JitW     = 7;
  localparam int unsigned RunW     = 9;
  localparam int unsigned HoldW    = 4;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam logic [HoldW-1:0] SwitchHoldoffDefault = 4'd3;

  // Reset values of the configuration registers.
  localparam logic [JitW-1:0]  ChangeLimitPctRst   = 7'd3;
  localparam logic [ExpW-1:0]  NightExpLimitRst    = 21'd1200000;
  localparam logic [ExpW-1:0]  DayExpLimitRst      = 21'd930000;
  localparam logic [ToneW-1:0] DayToneLimitRst     = 8'd14;
  localparam logic [ToneW-1:0] DayRunNeededRst     = 8'd10;
  localparam logic [TempW-1:0] WarmLightLimitRst   = 16'd3000;
  localparam logic [ToneW-1:0] WarmToneLimitRst    = 8'd17;
  localparam logic [ToneW-1:0] WarmRunNeededRst    = 8'd8;

  typedef enum logic [CfgIdxW-1:0] {
    RegChangeLimitPct  = 8'd0,
    RegNightExpLimit   = 8'd1,
    RegDayExpLimit     = 8'd2,
    RegDayToneLimit    = 8'd3,
    RegDayRunNeeded    = 8'd4,
    RegWarmLightLimit  = 8'd5,
    RegWarmToneLimit   = 8'd6,
    RegWarmRunNeeded   = 8'd7
  } edn_reg_e;

  typedef enum logic [2:0] {
    DecNone      = 3'd0,
    DecJitter    = 3'd1,
    DecHoldoff   = 3'd2,
    DecNight     = 3'd3,
    DecLowExpDay = 3'd4,
    DecWarmDay   = 3'd5
  } edn_dec_e;

  typedef struct packed {
    logic [ExpW-1:0]  exposure_level;
    logic [ToneW-1:0] tone_strength;
    logic [TempW-1:0] color_temp;
  } edn_in_t;

  typedef struct packed {
    logic     night_on;
    logic     mode_changed;
    edn_dec_e decision;
  } edn_out_t;

  typedef struct packed {
    logic [JitW-1:0]  change_limit_pct;
    logic [ExpW-1:0]  night_exposure_limit;
    logic [ExpW-1:0]  day_exposure_limit;
    logic [ToneW-1:0] day_tone_limit;
    logic [ToneW-1:0] day_run_needed;
    logic [TempW-1:0] warm_light_limit;
    logic [ToneW-1:0] warm_tone_limit;
    logic [ToneW-1:0] warm_run_needed;
  } edn_cfg_t;

endpackage

// File: rtl/exposure_day_night_decider_core.sv
`timescale 1ns / 1ps
// Top level of the exposure day/night decider: input register, decision logic, result register.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one camera statistics
//   sample per transaction: exposure level, tone strength and color temperature.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns one result per
//   sample: the mode after the sample, whether it switched, and the decision code.
//   A transaction completes at a rising edge with valid high and stall low.
//   Configuration registers are written through cfg_valid_i / cfg_ready_o with a
//   register index and data; cfg_ready_o is always high. Write only while idle.
// Timing:
//   The sample enters the input register at its accepting edge and its result is then
//   loaded into the result register, from which the result transaction is taken.
//   Throughput is one sample per cycle while out_stall_i does not hold a valid result.
// Reset:
//   Asynchronous, active low. Clears both valid flags, loads the register defaults,
//   starts in day mode with the hold-off counter loaded.
// Backpressure:
//   While out_stall_i holds a valid result, the input register still takes one
//   more sample; in_stall_o rises once that register is full and cannot drain.
module exposure_day_night_decider_core #(
  parameter logic [edn_pkg::HoldW-1:0] SwitchHoldoff = edn_pkg::SwitchHoldoffDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  edn_pkg::edn_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output edn_pkg::edn_out_t            out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [edn_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [edn_pkg::CfgDataW-1:0] cfg_data_i
);

  edn_pkg::edn_cfg_t cfg;
  edn_pkg::edn_in_t  in_q;
  logic              in_valid_q;
  edn_pkg::edn_out_t result;
  edn_pkg::edn_out_t out_q;
  logic              out_valid_q;
  logic              advance;
  logic              step;
  logic              in_take;

  assign advance     = !out_valid_q || !out_stall_i;
  assign step        = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  edn_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  edn_decide #(
    .SwitchHoldoff (SwitchHoldoff)
  ) u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

endmodule

// File: rtl/edn_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the exposure day/night decider.
module edn_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [edn_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [edn_pkg::CfgDataW-1:0]       cfg_data_i,
  output edn_pkg::edn_cfg_t                  cfg_o
);

  edn_pkg::edn_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      // Writes to indexes beyond the register list are dropped.
      case (cfg_index_i)
        edn_pkg::RegChangeLimitPct:
          cfg_d.change_limit_pct = cfg_data_i[edn_pkg::JitW-1:0];
        edn_pkg::RegNightExpLimit:
          cfg_d.night_exposure_limit = cfg_data_i[edn_pkg::ExpW-1:0];
        edn_pkg::RegDayExpLimit:
          cfg_d.day_exposure_limit = cfg_data_i[edn_pkg::ExpW-1:0];
        edn_pkg::RegDayToneLimit:
          cfg_d.day_tone_limit = cfg_data_i[edn_pkg::ToneW-1:0];
        edn_pkg::RegDayRunNeeded:
          cfg_d.day_run_needed = cfg_data_i[edn_pkg::ToneW-1:0];
        edn_pkg::RegWarmLightLimit:
          cfg_d.warm_light_limit = cfg_data_i[edn_pkg::TempW-1:0];
        edn_pkg::RegWarmToneLimit:
          cfg_d.warm_tone_limit = cfg_data_i[edn_pkg::ToneW-1:0];
        edn_pkg::RegWarmRunNeeded:
          cfg_d.warm_run_needed = cfg_data_i[edn_pkg::ToneW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.change_limit_pct     <= edn_pkg::ChangeLimitPctRst;
      cfg_q.night_exposure_limit <= edn_pkg::NightExpLimitRst;
      cfg_q.day_exposure_limit   <= edn_pkg::DayExpLimitRst;
      cfg_q.day_tone_limit       <= edn_pkg::DayToneLimitRst;
      cfg_q.day_run_needed       <= edn_pkg::DayRunNeededRst;
      cfg_q.warm_light_limit     <= edn_pkg::WarmLightLimitRst;
      cfg_q.warm_tone_limit      <= edn_pkg::WarmToneLimitRst;
      cfg_q.warm_run_needed      <= edn_pkg::WarmRunNeededRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/edn_decide.sv
`timescale 1ns / 1ps
// Decision logic and mode state: jitter test, hold-off, night and day switching.
module edn_decide #(
  parameter logic [edn_pkg::HoldW-1:0] SwitchHoldoff = edn_pkg::SwitchHoldoffDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  edn_pkg::edn_in_t  sample_i,
  input  edn_pkg::edn_cfg_t cfg_i,
  output edn_pkg::edn_out_t result_o
);

  localparam int unsigned ExpW  = edn_pkg::ExpW;
  localparam int unsigned RunW  = edn_pkg::RunW;
  localparam int unsigned HoldW = edn_pkg::HoldW;
  localparam int unsigned LhsW  = ExpW + 7;
  localparam int unsigned RhsW  = ExpW + edn_pkg::JitW + 1;
  localparam int unsigned CmpW  = (LhsW > RhsW) ? LhsW : RhsW;
  localparam logic [RunW-1:0] RunMax = {RunW{1'b1}};

  logic [ExpW-1:0]  prev_exp_q, prev_exp_d;
  logic             night_q, night_d;
  logic [HoldW-1:0] hold_q, hold_d;
  logic [RunW-1:0]  low_run_q, low_run_d;
  logic [RunW-1:0]  warm_run_q, warm_run_d;

  logic [ExpW-1:0]           diff;
  logic [LhsW-1:0]           lhs;
  logic [RhsW-1:0]           rhs;
  logic [edn_pkg::JitW:0]    jit_scale;
  logic                      jitter;
  logic [RunW-1:0]           low_inc, warm_inc;
  logic                      low_cond, warm_cond;
  logic                      switched;

  assign diff      = (sample_i.exposure_level >= prev_exp_q) ?
                     (sample_i.exposure_level - prev_exp_q) :
                     (prev_exp_q - sample_i.exposure_level);
  assign lhs       = LhsW'(diff) * LhsW'(100);
  assign jit_scale = {1'b0, cfg_i.change_limit_pct} + 1'b1;
  assign rhs       = RhsW'(jit_scale) * RhsW'(sample_i.exposure_level);
  // Integer form of a relative change test; zero exposure is always unstable.
  assign jitter    = (sample_i.exposure_level == '0) || (CmpW'(lhs) >= CmpW'(rhs));

  assign low_inc   = (low_run_q == RunMax) ? RunMax : low_run_q + 1'b1;
  assign warm_inc  = (warm_run_q == RunMax) ? RunMax : warm_run_q + 1'b1;
  assign low_cond  = night_q && (sample_i.exposure_level < cfg_i.day_exposure_limit) &&
                     (sample_i.tone_strength < cfg_i.day_tone_limit);
  assign warm_cond = night_q && (sample_i.color_temp < cfg_i.warm_light_limit) &&
                     (sample_i.tone_strength > cfg_i.warm_tone_limit);

  always_comb begin
    prev_exp_d            = sample_i.exposure_level;
    night_d               = night_q;
    hold_d                = hold_q;
    low_run_d             = low_run_q;
    warm_run_d            = warm_run_q;
    switched              = 1'b0;
    result_o.mode_changed = 1'b0;
    result_o.decision     = edn_pkg::DecNone;
    if (jitter) begin
      low_run_d         = '0;
      warm_run_d        = '0;
      result_o.decision = edn_pkg::DecJitter;
    end else if (hold_q != '0) begin
      hold_d            = hold_q - 1'b1;
      result_o.decision = edn_pkg::DecHoldoff;
    end else if (!night_q && (sample_i.exposure_level > cfg_i.night_exposure_limit)) begin
      night_d               = 1'b1;
      low_run_d             = '0;
      warm_run_d            = '0;
      hold_d                = SwitchHoldoff;
      result_o.mode_changed = 1'b1;
      result_o.decision     = edn_pkg::DecNight;
    end else begin
      if (low_cond) begin
        low_run_d = low_inc;
        if (low_inc > RunW'(cfg_i.day_run_needed)) begin
          night_d               = 1'b0;
          hold_d                = SwitchHoldoff;
          switched              = 1'b1;
          result_o.mode_changed = 1'b1;
          result_o.decision     = edn_pkg::DecLowExpDay;
        end
      end else begin
        low_run_d = '0;
      end
      // The warm-light run is left untouched when the low-exposure run switched.
      if (!switched) begin
        if (warm_cond) begin
          warm_run_d = warm_inc;
          if (warm_inc > RunW'(cfg_i.warm_run_needed)) begin
            night_d               = 1'b0;
            hold_d                = SwitchHoldoff;
            result_o.mode_changed = 1'b1;
            result_o.decision     = edn_pkg::DecWarmDay;
          end
        end else begin
          warm_run_d = '0;
        end
      end
    end
    result_o.night_on = night_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_exp_q <= '0;
      night_q    <= 1'b0;
      hold_q     <= SwitchHoldoff;
      low_run_q  <= '0;
      warm_run_q <= '0;
    end else if (step_i) begin
      prev_exp_q <= prev_exp_d;
      night_q    <= night_d;
      hold_q     <= hold_d;
      low_run_q  <= low_run_d;
      warm_run_q <= warm_run_d;
    end
  end

endmodule

// File: rtl/edn_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the exposure day/night decider and its bind to the top level.
module edn_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input edn_pkg::edn_out_t out_data_o
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result transaction changed");

  // A switch to night always reports night mode.
  a_night_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.decision == edn_pkg::DecNight)
      |-> out_data_o.night_on && out_data_o.mode_changed)
    else $error("night switch without night mode");

  // A switch back to day always reports day mode.
  a_day_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.decision == edn_pkg::DecLowExpDay) ||
                    (out_data_o.decision == edn_pkg::DecWarmDay))
      |-> !out_data_o.night_on && out_data_o.mode_changed)
    else $error("day switch without day mode");

  // Only the three switching decisions may flag a mode change.
  a_change_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mode_changed
      |-> (out_data_o.decision == edn_pkg::DecNight) ||
          (out_data_o.decision == edn_pkg::DecLowExpDay) ||
          (out_data_o.decision == edn_pkg::DecWarmDay))
    else $error("mode change flagged on a non-switching decision");

endmodule

bind exposure_day_night_decider_core edn_checker u_edn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: dv/exposure_day_night_decider_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the exposure day/night decider: directed cases, then random scenes.
module exposure_day_night_decider_core_test;

  localparam int unsigned ExpW     = edn_pkg::ExpW;
  localparam int unsigned ToneW    = edn_pkg::ToneW;
  localparam int unsigned TempW    = edn_pkg::TempW;
  localparam int unsigned JitW     = edn_pkg::JitW;
  localparam int unsigned RunW     = edn_pkg::RunW;
  localparam int unsigned HoldW    = edn_pkg::HoldW;
  localparam int unsigned CfgIdxW  = edn_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = edn_pkg::CfgDataW;

  localparam int unsigned ExpMax      = (1 << ExpW) - 1;
  localparam int unsigned ToneMax     = (1 << ToneW) - 1;
  localparam int unsigned TempMax     = (1 << TempW) - 1;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned RandomPhases = 11;
  localparam logic [JitW-1:0]    ChangeLimitPctMax = 7'd100;
  localparam logic [CfgIdxW-1:0] UnusedRegLow      = 8'd8;

  typedef enum logic [1:0] {
    SceneBright,
    SceneDark,
    SceneWarm,
    SceneNoise
  } scene_e;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid  = 1'b0;
  logic                in_stall_o;
  edn_pkg::edn_in_t    in_data   = '0;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  edn_pkg::edn_out_t   out_data_o;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // Register copy and decision state of the predictor.
  edn_pkg::edn_cfg_t cfg_shadow = '{
    change_limit_pct:     edn_pkg::ChangeLimitPctRst,
    night_exposure_limit: edn_pkg::NightExpLimitRst,
    day_exposure_limit:   edn_pkg::DayExpLimitRst,
    day_tone_limit:       edn_pkg::DayToneLimitRst,
    day_run_needed:       edn_pkg::DayRunNeededRst,
    warm_light_limit:     edn_pkg::WarmLightLimitRst,
    warm_tone_limit:      edn_pkg::WarmToneLimitRst,
    warm_run_needed:      edn_pkg::WarmRunNeededRst
  };
  logic [ExpW-1:0]  prev_level   = '0;
  logic             night_mode   = 1'b0;
  logic [HoldW-1:0] holdoff_cnt  = edn_pkg::SwitchHoldoffDefault;
  logic [RunW-1:0]  dark_run     = '0;
  logic [RunW-1:0]  warm_run     = '0;

  edn_pkg::edn_out_t pending_decisions[$];
  int unsigned decisions_seen[6];
  int unsigned samples_sent = 0;
  int unsigned settings_used = 1;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;

  exposure_day_night_decider_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               pending_decisions.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("Mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // Works out the result of one sample and advances the predictor state.
  function automatic edn_pkg::edn_out_t predict_decision(input edn_pkg::edn_in_t s);
    edn_pkg::edn_out_t r;
    longint unsigned   diff;
    longint unsigned   scaled_diff;
    longint unsigned   bound;
    logic              unstable;
    edn_pkg::edn_dec_e dec;
    logic              changed;
    diff = (s.exposure_level >= prev_level) ? s.exposure_level - prev_level
                                            : prev_level - s.exposure_level;
    scaled_diff = 64'd100 * diff;
    bound = (64'(cfg_shadow.change_limit_pct) + 64'd1) * 64'(s.exposure_level);
    unstable = (s.exposure_level == '0) || (scaled_diff >= bound);
    prev_level = s.exposure_level;
    changed = 1'b0;
    dec = edn_pkg::DecNone;
    if (unstable) begin
      dark_run = '0;
      warm_run = '0;
      dec = edn_pkg::DecJitter;
    end else if (holdoff_cnt != '0) begin
      holdoff_cnt = holdoff_cnt - 1'b1;
      dec = edn_pkg::DecHoldoff;
    end else if (!night_mode && s.exposure_level > cfg_shadow.night_exposure_limit) begin
      night_mode = 1'b1;
      dark_run = '0;
      warm_run = '0;
      holdoff_cnt = edn_pkg::SwitchHoldoffDefault;
      changed = 1'b1;
      dec = edn_pkg::DecNight;
    end else begin
      if (night_mode && s.exposure_level < cfg_shadow.day_exposure_limit &&
          s.tone_strength < cfg_shadow.day_tone_limit) begin
        if (dark_run != '1) dark_run = dark_run + 1'b1;
        if (dark_run > cfg_shadow.day_run_needed) begin
          night_mode = 1'b0;
          holdoff_cnt = edn_pkg::SwitchHoldoffDefault;
          changed = 1'b1;
          dec = edn_pkg::DecLowExpDay;
        end
      end else begin
        dark_run = '0;
      end
      // A low-exposure switch ends the sample before the warm-light check.
      if (dec == edn_pkg::DecNone) begin
        if (night_mode && s.color_temp < cfg_shadow.warm_light_limit &&
            s.tone_strength > cfg_shadow.warm_tone_limit) begin
          if (warm_run != '1) warm_run = warm_run + 1'b1;
          if (warm_run > cfg_shadow.warm_run_needed) begin
            night_mode = 1'b0;
            holdoff_cnt = edn_pkg::SwitchHoldoffDefault;
            changed = 1'b1;
            dec = edn_pkg::DecWarmDay;
          end
        end else begin
          warm_run = '0;
        end
      end
    end
    decisions_seen[dec]++;
    r.night_on = night_mode;
    r.mode_changed = changed;
    r.decision = dec;
    return r;
  endfunction

  function automatic edn_pkg::edn_in_t make_sample(input int unsigned exposure,
                                                   input int unsigned tone,
                                                   input int unsigned temp);
    edn_pkg::edn_in_t s;
    s.exposure_level = ExpW'(exposure);
    s.tone_strength = ToneW'(tone);
    s.color_temp = TempW'(temp);
    return s;
  endfunction

  // Leaves valid high on return so that back-to-back samples need no extra edge.
  task automatic send_sample(input edn_pkg::edn_in_t s);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_decisions.push_back(predict_decision(s));
    samples_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Leaves the write valid high; the caller lowers it after the last transaction.
  task automatic write_register(input logic [CfgIdxW-1:0] index,
                                input logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (index)
      edn_pkg::RegChangeLimitPct: cfg_shadow.change_limit_pct = value[JitW-1:0];
      edn_pkg::RegNightExpLimit:  cfg_shadow.night_exposure_limit = value[ExpW-1:0];
      edn_pkg::RegDayExpLimit:    cfg_shadow.day_exposure_limit = value[ExpW-1:0];
      edn_pkg::RegDayToneLimit:   cfg_shadow.day_tone_limit = value[ToneW-1:0];
      edn_pkg::RegDayRunNeeded:   cfg_shadow.day_run_needed = value[ToneW-1:0];
      edn_pkg::RegWarmLightLimit: cfg_shadow.warm_light_limit = value[TempW-1:0];
      edn_pkg::RegWarmToneLimit:  cfg_shadow.warm_tone_limit = value[ToneW-1:0];
      edn_pkg::RegWarmRunNeeded:  cfg_shadow.warm_run_needed = value[ToneW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input edn_pkg::edn_cfg_t c);
    wait_drained();
    write_register(edn_pkg::RegChangeLimitPct, CfgDataW'(c.change_limit_pct));
    write_register(edn_pkg::RegNightExpLimit, CfgDataW'(c.night_exposure_limit));
    write_register(edn_pkg::RegDayExpLimit, CfgDataW'(c.day_exposure_limit));
    write_register(edn_pkg::RegDayToneLimit, CfgDataW'(c.day_tone_limit));
    write_register(edn_pkg::RegDayRunNeeded, CfgDataW'(c.day_run_needed));
    write_register(edn_pkg::RegWarmLightLimit, CfgDataW'(c.warm_light_limit));
    write_register(edn_pkg::RegWarmToneLimit, CfgDataW'(c.warm_tone_limit));
    write_register(edn_pkg::RegWarmRunNeeded, CfgDataW'(c.warm_run_needed));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  always @(posedge clk_i) begin : check_results
    edn_pkg::edn_out_t want;
    if (rst_n && out_valid_o === 1'b1 && out_stall === 1'b0) begin
      if (pending_decisions.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with nothing expected", out_data_o));
      end else begin
        want = pending_decisions.pop_front();
        if (out_data_o.night_on !== want.night_on)
          report_mismatch($sformatf("night_on %b, expected %b", out_data_o.night_on,
                                    want.night_on));
        if (out_data_o.mode_changed !== want.mode_changed)
          report_mismatch($sformatf("mode_changed %b, expected %b",
                                    out_data_o.mode_changed, want.mode_changed));
        if (out_data_o.decision !== want.decision)
          report_mismatch($sformatf("decision %0d, expected %s", out_data_o.decision,
                                    want.decision.name()));
      end
    end
  end

  initial begin : stall_bursts
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Runs on the reset register values: zero exposure, field extremes, jitter while the
  // hold-off is running, and both sides of the exact jitter boundary.
  task automatic test_jitter_and_holdoff();
    send_sample(make_sample(0, 0, 0));
    send_sample(make_sample(ExpMax, ToneMax, TempMax));
    send_sample(make_sample(ExpMax, ToneMax, TempMax));
    send_sample(make_sample(1000000, 128, 4000));
    repeat (3) send_sample(make_sample(1000000, 5, 2000));
    send_sample(make_sample(1040, 85, 43690));
    send_sample(make_sample(1000, 170, 21845));
    send_sample(make_sample(1039, 0, 0));
    send_sample(make_sample(1000, 0, 0));
  endtask

  // Night switch, low-exposure day switch with the warm run kept and then cleared by a
  // plain day sample, and a warm-light day switch.
  task automatic test_switches_and_held_runs();
    edn_pkg::edn_cfg_t c;
    c.change_limit_pct = ChangeLimitPctMax;
    c.night_exposure_limit = 21'd1500000;
    c.day_exposure_limit = 21'd500000;
    c.day_tone_limit = 8'd20;
    c.day_run_needed = 8'd2;
    c.warm_light_limit = 16'd3000;
    c.warm_tone_limit = 8'd10;
    c.warm_run_needed = 8'd3;
    apply_config(c);
    repeat (4) send_sample(make_sample(1600000, 30, 50000));
    repeat (6) send_sample(make_sample(400000, 15, 1000));
    repeat (2) send_sample(make_sample(1000000, 30, 50000));
    repeat (4) send_sample(make_sample(1600000, 30, 50000));
    repeat (5) send_sample(make_sample(1000000, 200, 1000));
  endtask

  // A write to an index past the last register must leave every register as it was.
  task automatic test_unused_register_index();
    wait_drained();
    write_register(CfgIdxW'($urandom_range(int'(UnusedRegLow), 255)), '1);
    cfg_valid <= 1'b0;
    repeat (3) send_sample(make_sample(1600000, 15, 1000));
  endtask

  task automatic play_scene(input scene_e kind, input int unsigned len);
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      level;
    int unsigned      spread;
    int unsigned      step;
    edn_pkg::edn_in_t s;
    lo = 1;
    hi = ExpMax;
    if (kind == SceneBright)
      lo = (cfg_shadow.night_exposure_limit < ExpMax) ? cfg_shadow.night_exposure_limit + 1
                                                      : ExpMax;
    if (kind == SceneDark)
      hi = (cfg_shadow.day_exposure_limit > 1) ? cfg_shadow.day_exposure_limit - 1 : 1;
    level = $urandom_range(lo, hi);
    for (int i = 0; i < len; i++) begin
      // Drift stays under half the jitter margin, so a scene other than noise is stable after
      // its first sample; an occasional jump breaks it.
      if (i != 0) begin
        if ($urandom_range(0, 19) == 0) begin
          level = $urandom_range(lo, hi);
        end else begin
          spread = (level * cfg_shadow.change_limit_pct) / 200;
          step = $urandom_range(0, spread);
          if ($urandom_range(0, 1) == 1)
            level = (level + step > hi) ? hi : level + step;
          else
            level = (level < lo + step) ? lo : level - step;
        end
      end
      s.exposure_level = ExpW'(level);
      s.tone_strength = ToneW'($urandom_range(0, ToneMax));
      s.color_temp = TempW'($urandom_range(0, TempMax));
      if (kind == SceneNoise)
        s.exposure_level = ($urandom_range(0, 7) == 0) ? '0 : ExpW'($urandom_range(0, ExpMax));
      if ($urandom_range(0, 9) != 0) begin
        if (kind == SceneDark && cfg_shadow.day_tone_limit != '0)
          s.tone_strength = ToneW'($urandom_range(0, cfg_shadow.day_tone_limit - 1));
        if (kind == SceneWarm) begin
          if (cfg_shadow.warm_tone_limit != ToneW'(ToneMax))
            s.tone_strength = ToneW'($urandom_range(cfg_shadow.warm_tone_limit + 1, ToneMax));
          if (cfg_shadow.warm_light_limit != '0)
            s.color_temp = TempW'($urandom_range(0, cfg_shadow.warm_light_limit - 1));
        end
      end
      send_sample(s);
      if ($urandom_range(0, 149) == 0) wait_drained();
    end
  endtask

  task automatic test_random_scenes();
    edn_pkg::edn_cfg_t c;
    int unsigned       phase_end;
    int unsigned       run_max;
    int unsigned       len;
    scene_e            kind;
    for (int p = 0; p < RandomPhases; p++) begin
      c.change_limit_pct = JitW'($urandom_range(0, 100));
      if ($urandom_range(0, 3) == 0)
        c.change_limit_pct = ($urandom_range(0, 1) == 1) ? ChangeLimitPctMax : '0;
      c.night_exposure_limit = ExpW'($urandom_range(1000, ExpMax));
      c.day_exposure_limit = ExpW'($urandom_range(0, c.night_exposure_limit));
      c.day_tone_limit = ToneW'($urandom_range(0, ToneMax));
      c.day_run_needed = ToneW'($urandom_range(0, 12));
      c.warm_light_limit = TempW'($urandom_range(0, TempMax));
      c.warm_tone_limit = ToneW'($urandom_range(0, ToneMax));
      c.warm_run_needed = ToneW'($urandom_range(0, 12));
      case (p)
        1: begin
          c = '0;
        end
        2: begin
          c = '1;
          c.change_limit_pct = ChangeLimitPctMax;
        end
        3: begin
          c.day_run_needed = '1;
          c.warm_run_needed = '1;
        end
        9: begin
          c.change_limit_pct = edn_pkg::ChangeLimitPctRst;
          c.night_exposure_limit = edn_pkg::NightExpLimitRst;
          c.day_exposure_limit = edn_pkg::DayExpLimitRst;
          c.day_tone_limit = edn_pkg::DayToneLimitRst;
          c.day_run_needed = edn_pkg::DayRunNeededRst;
          c.warm_light_limit = edn_pkg::WarmLightLimitRst;
          c.warm_tone_limit = edn_pkg::WarmToneLimitRst;
          c.warm_run_needed = edn_pkg::WarmRunNeededRst;
        end
        default: ;
      endcase
      apply_config(c);
      idle_on = (p != RandomPhases - 1);
      run_max = (c.day_run_needed > c.warm_run_needed) ? c.day_run_needed : c.warm_run_needed;
      phase_end = samples_sent + ((p == 3) ? 600 : 110);
      while (samples_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2: kind = SceneBright;
          3, 4, 5: kind = SceneDark;
          6, 7:    kind = SceneWarm;
          default: kind = SceneNoise;
        endcase
        case (kind)
          SceneBright: len = $urandom_range(2, 8);
          SceneNoise:  len = $urandom_range(1, 6);
          default: begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, run_max + 4)
                                              : run_max + $urandom_range(3, 8);
          end
        endcase
        play_scene(kind, len);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_jitter_and_holdoff();
    test_switches_and_held_runs();
    test_unused_register_index();
    test_random_scenes();
    wait_drained();
    $display("Checked %0d samples over %0d register sets, with idling on both sides.",
             samples_sent, settings_used);
    $display("Mix: none %0d, jitter %0d, holdoff %0d, night %0d, low-exp day %0d, warm day %0d",
             decisions_seen[edn_pkg::DecNone], decisions_seen[edn_pkg::DecJitter],
             decisions_seen[edn_pkg::DecHoldoff], decisions_seen[edn_pkg::DecNight],
             decisions_seen[edn_pkg::DecLowExpDay], decisions_seen[edn_pkg::DecWarmDay]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
